### rtl/core/msfn_pkg.sv
// Shared types and constants for the moisture sample filter and normalizer.
`timescale 1ns / 1ps
`default_nettype none

package msfn_pkg;

    localparam logic [3:0] MIN_GOOD_READS  = 4'd3;
    localparam logic [3:0] READS_PER_BURST = 4'd8;
    localparam logic [3:0] FAULT_LIMIT     = 4'd10;

    localparam logic [16:0] Q_ONE = 17'd65536;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] REG_SENSOR_PRESENT = 2'd0;
    localparam logic [1:0] REG_DRY_LEVEL      = 2'd1;
    localparam logic [1:0] REG_WET_LEVEL      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic prep;
        logic div_step;
        logic div_last;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_norm;
        logic direct;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/moisture_sample_filter_normalizer.sv
// Top level of the moisture sample filter and normalizer with its APB register port.
//
//   channel   dir  handshake                   payload
//   sample    in   sample_valid/sample_stall   valid_count stable selected_reading latest_raw
//   result    out  result_valid/result_stall   raw_level filtered_level moisture fault error_run
//   config    in   APB psel/penable/pready     paddr pwdata prdata
//
// A good sample that needs the divider holds the core through accept, state update, range
// setup, 16 restoring divider steps and result load; the result is valid once it loads.
// A good sample whose moisture clamps skips the divider steps; other samples skip range setup too.
// One item is in work at a time; it waits to load the result only while the last one stalls.
// rst_n clears all sample state and sets the calibration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module moisture_sample_filter_normalizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire logic [3:0]  valid_count,
    input  wire logic        stable,
    input  wire logic [15:0] selected_reading,
    input  wire logic [15:0] latest_raw,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      raw_level,
    output logic [15:0]      filtered_level,
    output logic [16:0]      moisture,
    output logic             fault,
    output logic [3:0]       error_run
);

    logic        sensor_reg;
    logic [15:0] dry_reg;
    logic [15:0] wet_reg;
    logic        wr_en;

    msfn_pkg::cmd_t    cmd;
    msfn_pkg::status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_reg <= 1'b0;
            dry_reg    <= 16'd0;
            wet_reg    <= 16'hFFFF;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                msfn_pkg::REG_SENSOR_PRESENT: sensor_reg <= pwdata[0];
                msfn_pkg::REG_DRY_LEVEL:      dry_reg    <= pwdata[15:0];
                msfn_pkg::REG_WET_LEVEL:      wet_reg    <= pwdata[15:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            msfn_pkg::REG_SENSOR_PRESENT: prdata = {31'd0, sensor_reg};
            msfn_pkg::REG_DRY_LEVEL:      prdata = {16'd0, dry_reg};
            msfn_pkg::REG_WET_LEVEL:      prdata = {16'd0, wet_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    msfn_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    msfn_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sensor_present   (sensor_reg),
        .dry_level        (dry_reg),
        .wet_level        (wet_reg),
        .valid_count      (valid_count),
        .stable           (stable),
        .selected_reading (selected_reading),
        .latest_raw       (latest_raw),
        .raw_level        (raw_level),
        .filtered_level   (filtered_level),
        .moisture         (moisture),
        .fault            (fault),
        .error_run        (error_run)
    );

`ifndef SYNTHESIS
    a_fault_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fault |-> error_run == msfn_pkg::FAULT_LIMIT)
        else $error("fault reported below the error limit");

    a_moisture_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> moisture <= msfn_pkg::Q_ONE)
        else $error("moisture above full scale");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("second item taken while one is in work");
`endif

endmodule

`default_nettype wire

### rtl/core/msfn_ctrl.sv
// Sequencing state machine for the moisture sample filter and normalizer.
`timescale 1ns / 1ps
`default_nettype none

module msfn_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    output logic                  result_valid,
    input  wire logic             result_stall,
    input  wire msfn_pkg::status_t status,
    output msfn_pkg::cmd_t        cmd
);

    msfn_pkg::state_t state_reg, state_next;
    logic [msfn_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= msfn_pkg::ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg;
        cmd               = '0;
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        unique case (state_reg)
            msfn_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = msfn_pkg::ST_EVAL;
                end
            end
            msfn_pkg::ST_EVAL:
            begin
                cmd.update = 1'b1;
                state_next = status.need_norm ? msfn_pkg::ST_PREP : msfn_pkg::ST_DONE;
            end
            msfn_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                cnt_next = '0;
                state_next = status.direct ? msfn_pkg::ST_DONE : msfn_pkg::ST_DIV;
            end
            msfn_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == msfn_pkg::DIV_CNT_W'(msfn_pkg::DIV_STEPS - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = msfn_pkg::ST_DONE;
                end
            end
            msfn_pkg::ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.load_out      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = msfn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msfn_pkg::ST_IDLE;
            end
        endcase
    end

    assign sample_stall = (state_reg != msfn_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

### rtl/core/msfn_dp.sv
// Datapath: sample state, IIR filter, restoring divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module msfn_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msfn_pkg::cmd_t   cmd,
    output msfn_pkg::status_t     status,
    input  wire logic             sensor_present,
    input  wire logic [15:0]      dry_level,
    input  wire logic [15:0]      wet_level,
    input  wire logic [3:0]       valid_count,
    input  wire logic             stable,
    input  wire logic [15:0]      selected_reading,
    input  wire logic [15:0]      latest_raw,
    output logic [15:0]           raw_level,
    output logic [15:0]           filtered_level,
    output logic [16:0]           moisture,
    output logic                  fault,
    output logic [3:0]            error_run
);

    // captured item
    logic [3:0]  count_reg;
    logic        stable_reg;
    logic [15:0] sel_reg;
    logic [15:0] latest_reg;

    // sample state
    logic [15:0] filter_reg, filter_next;
    logic        loaded_reg, loaded_next;
    logic [3:0]  bad_reg, bad_next;
    logic [16:0] moist_reg, moist_next;
    logic        fault_reg, fault_next;
    logic [15:0] last_reg, last_next;

    // divider
    logic [15:0] range_reg, range_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;

    // result
    logic [15:0] raw_out_reg;
    logic [15:0] filt_out_reg;
    logic [16:0] moist_out_reg;
    logic        fault_out_reg;
    logic [3:0]  err_out_reg;

    logic [3:0]  count_eff;
    logic        few;
    logic [3:0]  bad_inc;
    logic [17:0] avg_sum;
    logic [16:0] diff;
    logic [16:0] rem_sh;

    assign count_eff = (count_reg > msfn_pkg::READS_PER_BURST) ?
                       msfn_pkg::READS_PER_BURST : count_reg;
    assign few       = (count_eff < msfn_pkg::MIN_GOOD_READS);
    assign bad_inc   = (bad_reg < msfn_pkg::FAULT_LIMIT) ? bad_reg + 4'd1 : bad_reg;
    assign avg_sum   = {2'b00, filter_reg} + {1'b0, filter_reg, 1'b0} + {2'b00, sel_reg};
    assign range_next = (wet_level > dry_level) ? (wet_level - dry_level) : 16'd1;
    assign diff      = {1'b0, filter_reg} - {1'b0, dry_level};
    assign rem_sh    = {rem_reg, 1'b0};

    assign status.need_norm = sensor_present && !few && stable_reg;
    assign status.direct    = (filter_reg <= dry_level) || (diff >= {1'b0, range_next});

    always_comb
    begin
        filter_next = filter_reg;
        loaded_next = loaded_reg;
        bad_next    = bad_reg;
        moist_next  = moist_reg;
        fault_next  = fault_reg;
        last_next   = last_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (cmd.update)
        begin
            if (!sensor_present)
            begin
                filter_next = '0;
                loaded_next = 1'b0;
                bad_next    = '0;
                moist_next  = '0;
                fault_next  = 1'b0;
                last_next   = '0;
            end
            else if (few)
            begin
                last_next  = latest_reg;
                bad_next   = bad_inc;
                fault_next = (bad_inc >= msfn_pkg::FAULT_LIMIT);
                if (!loaded_reg)
                    moist_next = '0;
            end
            else if (!stable_reg)
            begin
                last_next  = sel_reg;
                bad_next   = bad_inc;
                fault_next = !loaded_reg && (bad_inc >= msfn_pkg::FAULT_LIMIT);
            end
            else
            begin
                last_next   = sel_reg;
                bad_next    = '0;
                fault_next  = 1'b0;
                loaded_next = 1'b1;
                filter_next = loaded_reg ? avg_sum[17:2] : sel_reg;
            end
        end
        if (cmd.prep)
        begin
            rem_next = diff[15:0];
            quo_next = '0;
            if (filter_reg <= dry_level)
                moist_next = '0;
            else if (diff >= {1'b0, range_next})
                moist_next = msfn_pkg::Q_ONE;
        end
        if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, range_reg})
            begin
                rem_next = 16'(rem_sh - {1'b0, range_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            if (cmd.div_last)
                moist_next = {1'b0, quo_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= '0;
            loaded_reg <= 1'b0;
            bad_reg    <= '0;
            moist_reg  <= '0;
            fault_reg  <= 1'b0;
            last_reg   <= '0;
        end
        else
        begin
            filter_reg <= filter_next;
            loaded_reg <= loaded_next;
            bad_reg    <= bad_next;
            moist_reg  <= moist_next;
            fault_reg  <= fault_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            count_reg  <= valid_count;
            stable_reg <= stable;
            sel_reg    <= selected_reading;
            latest_reg <= latest_raw;
        end
        if (cmd.prep)
            range_reg <= range_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load_out)
        begin
            raw_out_reg   <= last_reg;
            filt_out_reg  <= filter_reg;
            moist_out_reg <= moist_reg;
            fault_out_reg <= fault_reg;
            err_out_reg   <= bad_reg;
        end
    end

    assign raw_level      = raw_out_reg;
    assign filtered_level = filt_out_reg;
    assign moisture       = moist_out_reg;
    assign fault          = fault_out_reg;
    assign error_run      = err_out_reg;

endmodule

`default_nettype wire
